// ----- hdl/clms_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and widths for the cpu load meter smoother
package clms_pkg;

    // field and register widths
    localparam int CPU_W      = 4;
    localparam int TICK_W     = 32;
    localparam int LEVEL_W    = 8;
    localparam int DECAY_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int NUM_CTR  = 11;
    localparam int NUM_LVL  = 5;
    localparam int CTR_W    = 4;
    localparam int LVL_W    = 3;
    localparam int SUM_W    = 35;
    localparam int TOT_W    = 36;
    localparam int NUM_W    = 44;
    localparam int PROD_W   = 48;
    localparam int MUL_B_W  = 17;
    localparam int MUL_W    = TICK_W + MUL_B_W;
    localparam int QBITS    = 8;
    localparam int DCNT_W   = 3;

    localparam logic [MUL_B_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INC_GFX = 1'd1;

    // counter slots
    localparam logic [CTR_W-1:0] CTR_IDLE       = 4'd0;
    localparam logic [CTR_W-1:0] CTR_USER       = 4'd1;
    localparam logic [CTR_W-1:0] CTR_KERNEL     = 4'd2;
    localparam logic [CTR_W-1:0] CTR_WAITING    = 4'd3;
    localparam logic [CTR_W-1:0] CTR_SXBRK      = 4'd4;
    localparam logic [CTR_W-1:0] CTR_INTR       = 4'd5;
    localparam logic [CTR_W-1:0] CTR_IO         = 4'd6;
    localparam logic [CTR_W-1:0] CTR_SWAP       = 4'd7;
    localparam logic [CTR_W-1:0] CTR_PIO        = 4'd8;
    localparam logic [CTR_W-1:0] CTR_GFXF       = 4'd9;
    localparam logic [CTR_W-1:0] CTR_GFXC       = 4'd10;
    localparam logic [CTR_W-1:0] CTR_FIRST_WAIT = CTR_IO;
    localparam logic [CTR_W-1:0] CTR_LAST       = CTR_GFXC;

    // level slots
    localparam logic [LVL_W-1:0] LVL_USER = 3'd0;
    localparam logic [LVL_W-1:0] LVL_SYS  = 3'd1;
    localparam logic [LVL_W-1:0] LVL_INTR = 3'd2;
    localparam logic [LVL_W-1:0] LVL_IO   = 3'd3;
    localparam logic [LVL_W-1:0] LVL_GFX  = 3'd4;

    // microcode
    localparam int OP_W = 4;
    localparam int JC_W = 3;
    localparam int PC_W = 5;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [JC_W-1:0] jc_t;
    typedef logic [PC_W-1:0] pc_t;

    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_IDLE     = 4'd1;
    localparam op_t OP_RD       = 4'd2;
    localparam op_t OP_MUL_OLD  = 4'd3;
    localparam op_t OP_MUL_NEW  = 4'd4;
    localparam op_t OP_TOT_LOAD = 4'd5;
    localparam op_t OP_TOT_ADD  = 4'd6;
    localparam op_t OP_DIV_INIT = 4'd7;
    localparam op_t OP_DIV_STEP = 4'd8;
    localparam op_t OP_DONE     = 4'd9;

    // branch kinds: IF jumps to target or falls through, WAIT holds until true
    localparam jc_t JC_NEXT       = 3'd0;
    localparam jc_t JC_GOTO       = 3'd1;
    localparam jc_t JC_IF_CTR     = 3'd2;
    localparam jc_t JC_IF_DIV     = 3'd3;
    localparam jc_t JC_IF_GFX     = 3'd4;
    localparam jc_t JC_WAIT_START = 3'd5;
    localparam jc_t JC_WAIT_OUT   = 3'd6;

    localparam pc_t PC_IDLE = 5'd0;

    typedef struct packed {
        op_t                op;
        jc_t                jc;
        pc_t                target;
        logic [CTR_W-1:0]   ctr_sel;
        logic [LVL_W-1:0]   lvl_sel;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic ctr_more;
        logic div_more;
        logic gfx_on;
        logic out_free;
    } cond_t;

endpackage

// ----- hdl/clms_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with registered read
module clms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 176
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/clms_seq.sv -----
`timescale 1ns / 1ps
// microcode sequencer: step counter, control rom and branch logic
module clms_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  clms_pkg::cond_t cond,
    output clms_pkg::ctrl_t ctrl
);
    import clms_pkg::*;

    // step addresses
    localparam pc_t A_IDLE      = PC_IDLE;
    localparam pc_t A_RD        = 5'd1;
    localparam pc_t A_MUL_OLD   = 5'd2;
    localparam pc_t A_MUL_NEW   = 5'd3;
    localparam pc_t A_USER_TOT  = 5'd4;
    localparam pc_t A_USER_INIT = 5'd5;
    localparam pc_t A_USER_DIV  = 5'd6;
    localparam pc_t A_SYS_ADD0  = 5'd7;
    localparam pc_t A_SYS_ADD1  = 5'd8;
    localparam pc_t A_SYS_INIT  = 5'd9;
    localparam pc_t A_SYS_DIV   = 5'd10;
    localparam pc_t A_INTR_ADD  = 5'd11;
    localparam pc_t A_INTR_INIT = 5'd12;
    localparam pc_t A_INTR_DIV  = 5'd13;
    localparam pc_t A_IO_ADD0   = 5'd14;
    localparam pc_t A_IO_ADD1   = 5'd15;
    localparam pc_t A_IO_ADD2   = 5'd16;
    // gfx folded into io
    localparam pc_t A_NG_ADD0   = 5'd17;
    localparam pc_t A_NG_ADD1   = 5'd18;
    localparam pc_t A_NG_INIT   = 5'd19;
    localparam pc_t A_NG_DIV    = 5'd20;
    localparam pc_t A_NG_DONE   = 5'd21;
    // separate gfx level
    localparam pc_t A_G_IO_INIT = 5'd22;
    localparam pc_t A_G_IO_DIV  = 5'd23;
    localparam pc_t A_G_ADD0    = 5'd24;
    localparam pc_t A_G_ADD1    = 5'd25;
    localparam pc_t A_G_INIT    = 5'd26;
    localparam pc_t A_G_DIV     = 5'd27;
    localparam pc_t A_G_DONE    = 5'd28;

    localparam logic [CTR_W-1:0] NO_CTR = CTR_IDLE;
    localparam logic [LVL_W-1:0] NO_LVL = LVL_USER;

    function automatic ctrl_t uword(input op_t op, input jc_t jc, input pc_t tgt,
                                    input logic [CTR_W-1:0] csel,
                                    input logic [LVL_W-1:0] lsel);
        ctrl_t w;
        w.op      = op;
        w.jc      = jc;
        w.target  = tgt;
        w.ctr_sel = csel;
        w.lvl_sel = lsel;
        return w;
    endfunction

    function automatic ctrl_t ucode_rom(input pc_t addr);
        ctrl_t w;
        unique case (addr)
            A_IDLE:      w = uword(OP_IDLE, JC_WAIT_START, A_RD, NO_CTR, NO_LVL);
            A_RD:        w = uword(OP_RD, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_MUL_OLD:   w = uword(OP_MUL_OLD, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_MUL_NEW:   w = uword(OP_MUL_NEW, JC_IF_CTR, A_RD, NO_CTR, NO_LVL);
            A_USER_TOT:  w = uword(OP_TOT_LOAD, JC_NEXT, A_IDLE, CTR_USER, NO_LVL);
            A_USER_INIT: w = uword(OP_DIV_INIT, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_USER_DIV:  w = uword(OP_DIV_STEP, JC_IF_DIV, A_USER_DIV, NO_CTR, LVL_USER);
            A_SYS_ADD0:  w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_KERNEL, NO_LVL);
            A_SYS_ADD1:  w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_SXBRK, NO_LVL);
            A_SYS_INIT:  w = uword(OP_DIV_INIT, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_SYS_DIV:   w = uword(OP_DIV_STEP, JC_IF_DIV, A_SYS_DIV, NO_CTR, LVL_SYS);
            A_INTR_ADD:  w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_INTR, NO_LVL);
            A_INTR_INIT: w = uword(OP_DIV_INIT, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_INTR_DIV:  w = uword(OP_DIV_STEP, JC_IF_DIV, A_INTR_DIV, NO_CTR, LVL_INTR);
            A_IO_ADD0:   w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_IO, NO_LVL);
            A_IO_ADD1:   w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_SWAP, NO_LVL);
            A_IO_ADD2:   w = uword(OP_TOT_ADD, JC_IF_GFX, A_G_IO_INIT, CTR_PIO, NO_LVL);
            A_NG_ADD0:   w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_GFXF, NO_LVL);
            A_NG_ADD1:   w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_GFXC, NO_LVL);
            A_NG_INIT:   w = uword(OP_DIV_INIT, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_NG_DIV:    w = uword(OP_DIV_STEP, JC_IF_DIV, A_NG_DIV, NO_CTR, LVL_IO);
            A_NG_DONE:   w = uword(OP_DONE, JC_WAIT_OUT, A_IDLE, NO_CTR, NO_LVL);
            A_G_IO_INIT: w = uword(OP_DIV_INIT, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_G_IO_DIV:  w = uword(OP_DIV_STEP, JC_IF_DIV, A_G_IO_DIV, NO_CTR, LVL_IO);
            A_G_ADD0:    w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_GFXF, NO_LVL);
            A_G_ADD1:    w = uword(OP_TOT_ADD, JC_NEXT, A_IDLE, CTR_GFXC, NO_LVL);
            A_G_INIT:    w = uword(OP_DIV_INIT, JC_NEXT, A_IDLE, NO_CTR, NO_LVL);
            A_G_DIV:     w = uword(OP_DIV_STEP, JC_IF_DIV, A_G_DIV, NO_CTR, LVL_GFX);
            A_G_DONE:    w = uword(OP_DONE, JC_WAIT_OUT, A_IDLE, NO_CTR, NO_LVL);
            default:     w = uword(OP_NOP, JC_GOTO, A_IDLE, NO_CTR, NO_LVL);
        endcase
        return w;
    endfunction

    pc_t pc_reg;
    pc_t pc_next;
    pc_t pc_inc;

    assign ctrl   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + 5'd1;

    always_comb
    begin
        unique case (ctrl.jc)
            JC_NEXT:       pc_next = pc_inc;
            JC_GOTO:       pc_next = ctrl.target;
            JC_IF_CTR:     pc_next = cond.ctr_more ? ctrl.target : pc_inc;
            JC_IF_DIV:     pc_next = cond.div_more ? ctrl.target : pc_inc;
            JC_IF_GFX:     pc_next = cond.gfx_on ? ctrl.target : pc_inc;
            JC_WAIT_START: pc_next = cond.start ? ctrl.target : pc_reg;
            JC_WAIT_OUT:   pc_next = cond.out_free ? ctrl.target : pc_reg;
            default:       pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- hdl/cpu_load_meter_smoother_core.sv -----
`timescale 1ns / 1ps
// top level of the per-cpu smoothed load meter
//
// usage
// - the host writes the decay weight (index 0, Q0.16 weight of the old average)
//   and the gfx select (index 1) through cfg_write_en / cfg_index / cfg_data while idle
// - each input request carries one cumulative tick sample for one cpu; the block
//   forms deltas against that cpu's stored sample, updates the smoothed averages
//   and returns one request with five 8-bit levels on the output channel
// - a sample whose cpu_index is not below CPU_COUNT is taken and dropped
// - a new sample is taken only when the sequencer is idle again. the microcode
//   sets the pace: three steps per counter through the shared 32x17 multiplier
//   and nine steps per level in the restoring divider, with one more level
//   when the gfx level is enabled
// - the output register frees the sequencer: a finished result may wait for
//   out_ready while the next sample is taken; a second result holds in the
//   final step until the first is gone
// - reset clears all row valid flags, so every cpu starts from zero history;
//   priming with a first sample is up to the host. no clearing pass is needed
module cpu_load_meter_smoother_core #(
    parameter int CPU_COUNT = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [clms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [clms_pkg::CPU_W-1:0]       cpu_index,
    input  logic [clms_pkg::TICK_W-1:0]      idle_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      user_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      kernel_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      waiting_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      sxbrk_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      intr_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      io_wait_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      swap_wait_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      pio_wait_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      gfxf_wait_ticks,
    input  logic [clms_pkg::TICK_W-1:0]      gfxc_wait_ticks,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [clms_pkg::CPU_W-1:0]       cpu_number,
    output logic [clms_pkg::LEVEL_W-1:0]     user_level,
    output logic [clms_pkg::LEVEL_W-1:0]     sys_level,
    output logic [clms_pkg::LEVEL_W-1:0]     intr_level,
    output logic [clms_pkg::LEVEL_W-1:0]     io_level,
    output logic [clms_pkg::LEVEL_W-1:0]     gfx_level
);
    import clms_pkg::*;

    localparam int DEPTH  = CPU_COUNT * NUM_CTR;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    // sequencer interface
    ctrl_t ctrl;
    cond_t cond;

    // configuration
    logic [DECAY_W-1:0] decay_reg;
    logic               gfx_on_reg;

    // current sample and row bookkeeping
    logic [TICK_W-1:0]  sample_reg [NUM_CTR];
    logic [CPU_W-1:0]   cpu_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CTR_W-1:0]   k_reg;
    logic               row_valid_reg [CPU_COUNT];

    // smoothing datapath
    logic [TICK_W-1:0]  delta_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TICK_W-1:0]  avg_reg [NUM_CTR];
    logic [SUM_W-1:0]   sum_reg;
    logic [TOT_W-1:0]   tot_reg;

    // level divider
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   dvs_reg;
    logic [QBITS-1:0]   q_reg;
    logic               sat_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic [LEVEL_W-1:0] lvl_reg [NUM_LVL];

    // output register
    logic               out_valid_reg;
    logic [CPU_W-1:0]   out_cpu_reg;
    logic [LEVEL_W-1:0] out_user_reg;
    logic [LEVEL_W-1:0] out_sys_reg;
    logic [LEVEL_W-1:0] out_intr_reg;
    logic [LEVEL_W-1:0] out_io_reg;
    logic [LEVEL_W-1:0] out_gfx_reg;

    // combinational
    logic               accept;
    logic               in_range;
    logic               start;
    logic               out_free;
    logic               done_fire;
    logic               row_ok;
    logic [ADDR_W-1:0]  base_addr;
    logic [TICK_W-1:0]  prev_rd;
    logic [TICK_W-1:0]  avg_rd;
    logic [TICK_W-1:0]  prev_val;
    logic [TICK_W-1:0]  old_val;
    logic [TICK_W-1:0]  cur_val;
    logic [TICK_W-1:0]  mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_W-1:0]   mul_p;
    logic [MUL_W-1:0]   mac;
    logic [TICK_W-1:0]  nv;
    logic               ram_we;
    logic [SUM_W-1:0]   sum_eff;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   dvs_top;
    logic               sat_now;
    logic               div_ge;
    logic [QBITS-1:0]   q_next;
    logic [LEVEL_W-1:0] lvl_next;

    // ------------------------------------------------------------------
    // handshake and sequencer conditions
    // ------------------------------------------------------------------
    assign in_ready  = (ctrl.op == OP_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_range  = (32'(cpu_index) < CPU_COUNT);
    assign start     = accept && in_range;
    assign out_free  = !out_valid_reg || out_ready;
    assign done_fire = (ctrl.op == OP_DONE) && out_free;

    assign cond.start    = start;
    assign cond.ctr_more = (k_reg != CTR_LAST);
    assign cond.div_more = (div_cnt_reg != '0);
    assign cond.gfx_on   = gfx_on_reg;
    assign cond.out_free = out_free;

    clms_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    // ------------------------------------------------------------------
    // history memories, one word per cpu and counter
    // ------------------------------------------------------------------
    assign ram_we    = (ctrl.op == OP_MUL_NEW);
    assign base_addr = ADDR_W'(32'(cpu_index) * NUM_CTR);

    clms_ram #(
        .WIDTH (TICK_W),
        .DEPTH (DEPTH)
    ) u_prev_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (cur_val),
        .rd_addr (addr_reg),
        .rd_data (prev_rd)
    );

    clms_ram #(
        .WIDTH (TICK_W),
        .DEPTH (DEPTH)
    ) u_avg_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (nv),
        .rd_addr (addr_reg),
        .rd_data (avg_rd)
    );

    // a row never written since reset reads as zero
    assign row_ok   = row_valid_reg[row_reg];
    assign prev_val = row_ok ? prev_rd : '0;
    assign old_val  = row_ok ? avg_rd : '0;
    assign cur_val  = sample_reg[k_reg];

    // ------------------------------------------------------------------
    // shared multiplier: old*d, then delta*(1-d) accumulated on top
    // ------------------------------------------------------------------
    assign mul_a = (ctrl.op == OP_MUL_OLD) ? old_val : delta_reg;
    assign mul_b = (ctrl.op == OP_MUL_OLD) ? MUL_B_W'(decay_reg)
                                           : ONE_Q16 - MUL_B_W'(decay_reg);
    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign mac   = MUL_W'(prod_reg) + mul_p;
    assign nv    = mac[TICK_W+15:16];

    // ------------------------------------------------------------------
    // level divider: (255*tot + sum/2) / sum, clamped at 255
    // ------------------------------------------------------------------
    assign sum_eff  = (sum_reg == '0) ? SUM_W'(1) : sum_reg;
    assign num      = (NUM_W'(tot_reg) << 8) - NUM_W'(tot_reg) + NUM_W'(sum_eff >> 1);
    assign dvs_top  = NUM_W'(sum_eff) << QBITS;
    assign sat_now  = (num >= dvs_top);
    assign div_ge   = (rem_reg >= dvs_reg);
    assign q_next   = {q_reg[QBITS-2:0], div_ge};
    assign lvl_next = sat_reg ? LEVEL_MAX : q_next;

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg     <= 16'd46341;
            gfx_on_reg    <= 1'b1;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CPU_COUNT; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_DECAY:   decay_reg  <= cfg_data;
                    REG_INC_GFX: gfx_on_reg <= cfg_data[0];
                endcase
            end

            if (start)
            begin
                k_reg <= '0;
            end

            unique case (ctrl.op)
                OP_MUL_NEW:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == CTR_LAST)
                    begin
                        row_valid_reg[row_reg] <= 1'b1;
                    end
                end
                OP_DIV_INIT: div_cnt_reg <= DCNT_W'(QBITS - 1);
                OP_DIV_STEP: div_cnt_reg <= div_cnt_reg - 3'd1;
                default:     ;
            endcase

            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg[CTR_IDLE]    <= idle_ticks;
            sample_reg[CTR_USER]    <= user_ticks;
            sample_reg[CTR_KERNEL]  <= kernel_ticks;
            sample_reg[CTR_WAITING] <= waiting_ticks;
            sample_reg[CTR_SXBRK]   <= sxbrk_ticks;
            sample_reg[CTR_INTR]    <= intr_ticks;
            sample_reg[CTR_IO]      <= io_wait_ticks;
            sample_reg[CTR_SWAP]    <= swap_wait_ticks;
            sample_reg[CTR_PIO]     <= pio_wait_ticks;
            sample_reg[CTR_GFXF]    <= gfxf_wait_ticks;
            sample_reg[CTR_GFXC]    <= gfxc_wait_ticks;
            cpu_reg                 <= cpu_index;
            row_reg                 <= ROW_W'(cpu_index);
            addr_reg                <= base_addr;
            sum_reg                 <= '0;
        end

        unique case (ctrl.op)
            OP_MUL_OLD:
            begin
                prod_reg  <= mul_p[PROD_W-1:0];
                delta_reg <= cur_val - prev_val;
            end
            OP_MUL_NEW:
            begin
                avg_reg[k_reg] <= nv;
                addr_reg       <= addr_reg + ADDR_W'(1);
                // only the six time counters make up the divisor
                if (k_reg < CTR_FIRST_WAIT)
                begin
                    sum_reg <= sum_reg + SUM_W'(nv);
                end
            end
            OP_TOT_LOAD:
            begin
                tot_reg          <= TOT_W'(avg_reg[ctrl.ctr_sel]);
                lvl_reg[LVL_GFX] <= '0;
            end
            OP_TOT_ADD:
            begin
                tot_reg <= tot_reg + TOT_W'(avg_reg[ctrl.ctr_sel]);
            end
            OP_DIV_INIT:
            begin
                rem_reg <= num;
                dvs_reg <= NUM_W'(sum_eff) << (QBITS - 1);
                sat_reg <= sat_now;
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg                <= dvs_reg >> 1;
                q_reg                  <= q_next;
                lvl_reg[ctrl.lvl_sel]  <= lvl_next;
            end
            default: ;
        endcase

        if (done_fire)
        begin
            out_cpu_reg  <= cpu_reg;
            out_user_reg <= lvl_reg[LVL_USER];
            out_sys_reg  <= lvl_reg[LVL_SYS];
            out_intr_reg <= lvl_reg[LVL_INTR];
            out_io_reg   <= lvl_reg[LVL_IO];
            out_gfx_reg  <= lvl_reg[LVL_GFX];
        end
    end

    assign out_valid  = out_valid_reg;
    assign cpu_number = out_cpu_reg;
    assign user_level = out_user_reg;
    assign sys_level  = out_sys_reg;
    assign intr_level = out_intr_reg;
    assign io_level   = out_io_reg;
    assign gfx_level  = out_gfx_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // levels come from growing totals over one divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_user_reg <= out_sys_reg) && (out_sys_reg <= out_intr_reg)
                          && (out_intr_reg <= out_io_reg))
        else $error("levels out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && gfx_on_reg |-> out_io_reg <= out_gfx_reg)
        else $error("gfx level below io level");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !gfx_on_reg |-> out_gfx_reg == '0)
        else $error("gfx level set while gfx is folded into io");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> row_valid_reg[row_reg])
        else $error("result without its row marked written");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_TOT_LOAD |-> k_reg == CTR_W'(NUM_CTR))
        else $error("counter loop left early");

endmodule
